@@ hw/rtl/msrb_pkg.sv @@
`timescale 1ns / 1ps

package msrb_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int ELEM_W = 16;
  localparam int MUL_W  = 2 * ELEM_W;
  localparam int PROD_W = 35;
  localparam int LOAD_W = 7;
  localparam int CFG_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RST  = 4'd8;
  localparam logic [2:0]       FIRST_RST = 3'd0;
  localparam logic [CFG_W-1:0] END_RST   = 4'd8;

  typedef struct packed {
    logic clear;
    logic step;
    logic last;
  } mac_ctrl_t;

endpackage

@@ hw/rtl/msrb_store.sv @@
`timescale 1ns / 1ps

module msrb_store #(
  parameter int DEPTH = msrb_pkg::MAX_DIM_DEF * msrb_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic signed [msrb_pkg::ELEM_W-1:0]  wr_data,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr_b,
  output logic signed [msrb_pkg::ELEM_W-1:0]  rd_data_a,
  output logic signed [msrb_pkg::ELEM_W-1:0]  rd_data_b
);

  logic signed [msrb_pkg::ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ hw/rtl/msrb_mac.sv @@
`timescale 1ns / 1ps

module msrb_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  msrb_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [msrb_pkg::ELEM_W-1:0]  op_a,
  input  logic signed [msrb_pkg::ELEM_W-1:0]  op_b,
  output logic signed [msrb_pkg::PROD_W-1:0]  acc,
  output logic                                done
);

  logic signed [msrb_pkg::MUL_W-1:0] prod;
  logic                              prod_valid;
  logic                              prod_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= ctrl.step;
      prod_last  <= ctrl.last;
      done       <= prod_valid && prod_last;
    end
    prod <= op_a * op_b;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(msrb_pkg::PROD_W - msrb_pkg::MUL_W){prod[msrb_pkg::MUL_W-1]}}, prod};
    end
  end

endmodule

@@ hw/rtl/matrix_square_row_block.sv @@
`timescale 1ns / 1ps

// channel | signals                              | role
// --------+--------------------------------------+-----------------------------
// in      | in_valid in_ready element_value      | one Q8.8 element, row-major
// out     | out_valid out_ready product_value    | one Q19.16 result element,
//         | last_result                          | last flag on final one
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | 0 size, 1 first, 2 end
//
// Loading accepts one element per cycle; in_ready is low while a block computes.
// Each result passes through the shared multiply-accumulate unit in steps:
// n reads, three pipeline stages, one emit, plus any output stall.
// Output stalls hold the sequencer in its emit step. cfg_ready is always high.
// Reset clears control and config; the matrix store is not cleared.

module matrix_square_row_block #(
  parameter int MAX_DIM = msrb_pkg::MAX_DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [msrb_pkg::ELEM_W-1:0]   element_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [msrb_pkg::PROD_W-1:0]   product_value,
  output logic                                 last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [msrb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msrb_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int AREA_W = $clog2(DEPTH + 1);
  localparam int LOAD_W = msrb_pkg::LOAD_W;
  localparam int CFG_W  = msrb_pkg::CFG_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  size_in_use;
  logic [2:0]        first_row;
  logic [CFG_W-1:0]  end_row;

  logic [LOAD_W-1:0] load_count;
  logic [IDX_W-1:0]  row_i;
  logic [IDX_W-1:0]  col_j;
  logic [IDX_W-1:0]  k_cnt;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic              rd_step;
  logic              rd_last;

  logic [DIM_W-1:0]  dim;
  logic [AREA_W-1:0] area;
  logic [CFG_W-1:0]  stop;
  logic [LOAD_W-1:0] count_next;
  logic              load_done;
  logic              block_empty;
  logic              last_k;
  logic              last_j;
  logic              last_i;
  logic              out_free;
  logic              emit_go;
  logic              wr_en;
  logic [ADDR_W-1:0] base_first;
  logic [ADDR_W-1:0] row_base_next;

  logic signed [msrb_pkg::ELEM_W-1:0] rd_a;
  logic signed [msrb_pkg::ELEM_W-1:0] rd_b;
  logic signed [msrb_pkg::PROD_W-1:0] acc;
  logic                               acc_done;
  msrb_pkg::mac_ctrl_t                mac_ctrl;

  always_comb begin
    if (size_in_use == '0) begin
      dim = DIM_W'(1);
    end else if (size_in_use > CFG_W'(MAX_DIM)) begin
      dim = DIM_W'(MAX_DIM);
    end else begin
      dim = DIM_W'(size_in_use);
    end
  end

  assign area          = AREA_W'(dim) * AREA_W'(dim);
  assign stop          = (end_row > CFG_W'(dim)) ? CFG_W'(dim) : end_row;
  assign block_empty   = (stop <= {1'b0, first_row});
  assign count_next    = load_count + LOAD_W'(1);
  assign load_done     = (count_next >= LOAD_W'(area));
  assign last_k        = (k_cnt == IDX_W'(dim - DIM_W'(1)));
  assign last_j        = (col_j == IDX_W'(dim - DIM_W'(1)));
  assign last_i        = (row_i == IDX_W'(stop - CFG_W'(1)));
  assign base_first    = ADDR_W'(first_row) * ADDR_W'(dim);
  assign row_base_next = row_base + ADDR_W'(dim);
  assign out_free      = !out_valid || out_ready;
  assign emit_go       = (state == ST_EMIT) && out_free;
  assign wr_en         = in_valid && in_ready && (load_count < LOAD_W'(DEPTH));

  assign in_ready  = (state == ST_LOAD);
  assign cfg_ready = 1'b1;

  assign mac_ctrl.clear = (state == ST_LOAD) || emit_go;
  assign mac_ctrl.step  = rd_step;
  assign mac_ctrl.last  = rd_last;

  msrb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (load_count[ADDR_W-1:0]),
    .wr_data   (element_value),
    .rd_addr_a (a_addr),
    .rd_addr_b (b_addr),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  msrb_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .op_a (rd_a),
    .op_b (rd_b),
    .acc  (acc),
    .done (acc_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= msrb_pkg::SIZE_RST;
      first_row   <= msrb_pkg::FIRST_RST;
      end_row     <= msrb_pkg::END_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msrb_pkg::CFG_SIZE:  size_in_use <= cfg_data;
        msrb_pkg::CFG_FIRST: first_row   <= cfg_data[2:0];
        msrb_pkg::CFG_END:   end_row     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      out_valid  <= 1'b0;
      rd_step    <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      rd_step <= (state == ST_ISSUE);
      rd_last <= (state == ST_ISSUE) && last_k;
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (load_done) begin
              load_count <= '0;
              if (!block_empty) begin
                row_i    <= IDX_W'(first_row);
                col_j    <= '0;
                k_cnt    <= '0;
                row_base <= base_first;
                a_addr   <= base_first;
                b_addr   <= '0;
                state    <= ST_ISSUE;
              end
            end else begin
              load_count <= count_next;
            end
          end
        end
        ST_ISSUE: begin
          a_addr <= a_addr + ADDR_W'(1);
          b_addr <= b_addr + ADDR_W'(dim);
          if (last_k) begin
            k_cnt <= '0;
            state <= ST_DRAIN;
          end else begin
            k_cnt <= k_cnt + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (acc_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            product_value <= acc;
            last_result   <= last_j && last_i;
            if (last_j) begin
              col_j  <= '0;
              b_addr <= '0;
              if (last_i) begin
                state <= ST_LOAD;
              end else begin
                row_i    <= row_i + IDX_W'(1);
                row_base <= row_base_next;
                a_addr   <= row_base_next;
                state    <= ST_ISSUE;
              end
            end else begin
              col_j  <= col_j + IDX_W'(1);
              a_addr <= row_base;
              b_addr <= ADDR_W'(col_j) + ADDR_W'(1);
              state  <= ST_ISSUE;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
